>>> src/qmul_pkg.sv
// Shared widths, types and constants for the quaternion multiply pipeline.
package qmul_pkg;

  localparam int CompWidth    = 16;
  localparam int FracBits     = 14;
  localparam int NumComp      = 4;
  localparam int ProdWidth    = 2 * CompWidth;
  localparam int SumWidth     = ProdWidth + 2;
  localparam int ShWidth      = SumWidth - FracBits;
  localparam int InDataWidth  = ((2 * NumComp * CompWidth + 7) / 8) * 8;
  localparam int OutDataWidth = ((NumComp * CompWidth + 1 + 7) / 8) * 8;

  typedef logic signed [CompWidth-1:0] comp_t;
  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef logic signed [SumWidth-1:0]  sum_t;
  typedef logic signed [ShWidth-1:0]   sh_t;

  // component order: 0 = w, 1 = x, 2 = y, 3 = z
  typedef comp_t quat_t  [NumComp];
  typedef prod_t prods_t [NumComp][NumComp];
  typedef sum_t  pairs_t [NumComp][2];
  typedef sh_t   shs_t   [NumComp];

  localparam sum_t RoundBias = sum_t'(1) <<< (FracBits - 1);

endpackage

>>> src/qmul_mult.sv
// Stage 1: sixteen component products of the Hamilton product, registered.
module qmul_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  qmul_pkg::quat_t a_i,
  input  qmul_pkg::quat_t b_i,
  output logic            valid_o,
  input  logic            ready_i,
  output qmul_pkg::prods_t prod_o
);

  // operand pairing per result component; term 0 is always a_w times a component
  localparam logic [1:0] AIdx [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                         '{2'd0, 2'd1, 2'd2, 2'd3},
                                         '{2'd0, 2'd2, 2'd3, 2'd1},
                                         '{2'd0, 2'd3, 2'd1, 2'd2}};
  localparam logic [1:0] BIdx [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                         '{2'd1, 2'd0, 2'd3, 2'd2},
                                         '{2'd2, 2'd0, 2'd1, 2'd3},
                                         '{2'd3, 2'd0, 2'd2, 2'd1}};

  logic             valid_q;
  logic             load;
  qmul_pkg::prods_t prod_d;
  qmul_pkg::prods_t prod_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    for (int c = 0; c < qmul_pkg::NumComp; c++) begin
      for (int k = 0; k < qmul_pkg::NumComp; k++) begin
        prod_d[c][k] = qmul_pkg::prod_t'(a_i[AIdx[c][k]]) *
                       qmul_pkg::prod_t'(b_i[BIdx[c][k]]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

>>> src/qmul_sum.sv
// Stages 2 and 3: signed pair sums, then total with rounding and fraction shift.
module qmul_sum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  qmul_pkg::prods_t  prod_i,
  output logic              valid_o,
  input  logic              ready_i,
  output qmul_pkg::shs_t    sh_o
);

  logic             pair_valid_q;
  logic             pair_ready;
  logic             tot_valid_q;
  qmul_pkg::pairs_t pair_d;
  qmul_pkg::pairs_t pair_q;
  qmul_pkg::shs_t   sh_d;
  qmul_pkg::shs_t   sh_q;
  qmul_pkg::sum_t   p [qmul_pkg::NumComp][qmul_pkg::NumComp];
  qmul_pkg::sum_t   tot [qmul_pkg::NumComp];

  assign ready_o    = !pair_valid_q || pair_ready;
  assign pair_ready = !tot_valid_q || ready_i;

  always_comb begin
    for (int c = 0; c < qmul_pkg::NumComp; c++) begin
      for (int k = 0; k < qmul_pkg::NumComp; k++) begin
        p[c][k] = qmul_pkg::sum_t'(prod_i[c][k]);
      end
    end
    // scalar part subtracts the dot product; vector parts subtract only the last cross term
    pair_d[0][0] = p[0][0] - p[0][1];
    pair_d[0][1] = -p[0][2] - p[0][3];
    for (int c = 1; c < qmul_pkg::NumComp; c++) begin
      pair_d[c][0] = p[c][0] + p[c][1];
      pair_d[c][1] = p[c][2] - p[c][3];
    end
  end

  always_comb begin
    for (int c = 0; c < qmul_pkg::NumComp; c++) begin
      tot[c]  = pair_q[c][0] + pair_q[c][1] + qmul_pkg::RoundBias;
      sh_d[c] = tot[c][qmul_pkg::SumWidth-1:qmul_pkg::FracBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      tot_valid_q  <= 1'b0;
    end else begin
      if (ready_o) begin
        pair_valid_q <= valid_i;
      end
      if (pair_ready) begin
        tot_valid_q <= pair_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pair_q <= pair_d;
    end
    if (pair_valid_q && pair_ready) begin
      sh_q <= sh_d;
    end
  end

  assign valid_o = tot_valid_q;
  assign sh_o    = sh_q;

endmodule

>>> src/qmul_sat.sv
// Stage 4: saturation to component width, overflow flag, output register.
module qmul_sat (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  qmul_pkg::shs_t  sh_i,
  output logic            valid_o,
  input  logic            ready_i,
  output qmul_pkg::quat_t prod_o,
  output logic            ovf_o
);

  localparam int TopBits = qmul_pkg::ShWidth - qmul_pkg::CompWidth + 1;
  localparam int NumTop  = qmul_pkg::NumComp;

  logic                  valid_q;
  logic                  ovf_d;
  logic                  ovf_q;
  logic [NumTop-1:0]     ovf_c;
  logic [TopBits-1:0]    top [qmul_pkg::NumComp];
  qmul_pkg::quat_t       prod_d;
  qmul_pkg::quat_t       prod_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int c = 0; c < qmul_pkg::NumComp; c++) begin
      top[c]   = sh_i[c][qmul_pkg::ShWidth-1:qmul_pkg::CompWidth-1];
      ovf_c[c] = !((&top[c]) || !(|top[c]));
      if (ovf_c[c]) begin
        prod_d[c] = {sh_i[c][qmul_pkg::ShWidth-1],
                     {(qmul_pkg::CompWidth-1){!sh_i[c][qmul_pkg::ShWidth-1]}}};
      end else begin
        prod_d[c] = sh_i[c][qmul_pkg::CompWidth-1:0];
      end
    end
    ovf_d = |ovf_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
      ovf_q  <= ovf_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign ovf_o   = ovf_q;

endmodule

>>> src/quaternion_multiply_unit.sv
// Top level: fixed-point quaternion Hamilton product, four-stage pipeline.
//
// One request on the slave stream carries two quaternions a and b, each
// component signed Q1.14. The master stream returns one request per input
// with the product a*b, rounded to nearest (ties up), saturated to 16 bits,
// plus an overflow flag set if any component saturated.
// Pipeline: products (16 multipliers), pair sums, total + round + shift,
// saturate into the output register. m_axis_tvalid_o rises once a request
// has passed the product, pair-sum and total registers into the output
// register; throughput is one request per cycle while the receiver does not
// stall, since every stage then takes new content each cycle.
// Each stage holds its own valid bit and accepts when empty or when the next
// stage takes its content, so bubbles are squeezed out while the receiver
// stalls; with m_axis_tready_i low and all four stages full, s_axis_tready_o
// drops. A stall loses and repeats nothing.
// Reset clears all valid bits; no request is in flight afterwards.
module quaternion_multiply_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (16 bits each)
  input  logic [qmul_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // prod_w, prod_x, prod_y, prod_z (16 bits each), overflow, 7 zero bits
  output logic [qmul_pkg::OutDataWidth-1:0] m_axis_tdata_o
);

  localparam int W = qmul_pkg::CompWidth;
  localparam int N = qmul_pkg::NumComp;

  qmul_pkg::quat_t  a;
  qmul_pkg::quat_t  b;
  qmul_pkg::prods_t prod;
  qmul_pkg::shs_t   sh;
  qmul_pkg::quat_t  res;
  logic             mul_valid;
  logic             mul_ready;
  logic             sum_valid;
  logic             sum_ready;
  logic             ovf;

  always_comb begin
    for (int c = 0; c < N; c++) begin
      a[c] = s_axis_tdata_i[c*W +: W];
      b[c] = s_axis_tdata_i[(c+N)*W +: W];
    end
  end

  qmul_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .a_i     (a),
    .b_i     (b),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .prod_o  (prod)
  );

  qmul_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .prod_i  (prod),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .sh_o    (sh)
  );

  qmul_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .sh_i    (sh),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .prod_o  (res),
    .ovf_o   (ovf)
  );

  always_comb begin
    m_axis_tdata_o = '0;
    for (int c = 0; c < N; c++) begin
      m_axis_tdata_o[c*W +: W] = res[c];
    end
    m_axis_tdata_o[N*W] = ovf;
  end

endmodule

>>> tb/sv/qmul_product_checker.sv
// Checker for the quaternion multiply unit: predicts each product and compares the results.
module qmul_product_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  input  logic                              s_ready_i,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (16 bits each)
  input  logic [qmul_pkg::InDataWidth-1:0]  s_data_i,
  input  logic                              m_valid_i,
  input  logic                              m_ready_i,
  // prod_w, prod_x, prod_y, prod_z (16 bits each), overflow, 7 zero bits
  input  logic [qmul_pkg::OutDataWidth-1:0] m_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CompWidth    = qmul_pkg::CompWidth;
  localparam int     FracBits     = qmul_pkg::FracBits;
  localparam int     NumComp      = qmul_pkg::NumComp;
  localparam int     InDataWidth  = qmul_pkg::InDataWidth;
  localparam int     OutDataWidth = qmul_pkg::OutDataWidth;
  localparam longint CompMax      = (longint'(1) <<< (CompWidth - 1)) - 1;
  localparam longint CompMin      = -CompMax - 1;
  localparam longint RoundHalf    = longint'(1) <<< (FracBits - 1);
  localparam int     OvfBit       = NumComp * CompWidth;

  typedef struct {
    qmul_pkg::quat_t comp;
    logic            ovf;
  } quat_prod_t;

  string comp_name [NumComp] = '{"w", "x", "y", "z"};

  quat_prod_t products_due [$];
  int         mismatches = 0;
  int         due_count  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = due_count;

  function automatic quat_prod_t hamilton_product(input logic [InDataWidth-1:0] operands);
    longint     a [NumComp];
    longint     b [NumComp];
    longint     sums [NumComp];
    longint     r;
    quat_prod_t res;
    for (int i = 0; i < NumComp; i++) begin
      a[i] = $signed(operands[i*CompWidth +: CompWidth]);
      b[i] = $signed(operands[(i+NumComp)*CompWidth +: CompWidth]);
    end
    sums[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
    sums[1] = a[0] * b[1] + b[0] * a[1] + a[2] * b[3] - a[3] * b[2];
    sums[2] = a[0] * b[2] + b[0] * a[2] + a[3] * b[1] - a[1] * b[3];
    sums[3] = a[0] * b[3] + b[0] * a[3] + a[1] * b[2] - a[2] * b[1];
    res.ovf = 1'b0;
    for (int i = 0; i < NumComp; i++) begin
      // round to nearest, ties up, then saturate
      r = (sums[i] + RoundHalf) >>> FracBits;
      if (r > CompMax) begin
        r       = CompMax;
        res.ovf = 1'b1;
      end else if (r < CompMin) begin
        r       = CompMin;
        res.ovf = 1'b1;
      end
      res.comp[i] = qmul_pkg::comp_t'(r);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    quat_prod_t      want;
    qmul_pkg::comp_t got;
    if (rst_ni) begin
      if (m_valid_i && m_ready_i) begin
        if (products_due.size() == 0) begin
          $display("%0t: unexpected request, expected none, actual %h", $time, m_data_i);
          mismatches++;
        end else begin
          want = products_due.pop_front();
          for (int i = 0; i < NumComp; i++) begin
            got = m_data_i[i*CompWidth +: CompWidth];
            if (got !== want.comp[i]) begin
              $display("%0t: prod_%s expected %0d actual %0d",
                       $time, comp_name[i], want.comp[i], got);
              mismatches++;
            end
          end
          if (m_data_i[OvfBit] !== want.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, m_data_i[OvfBit]);
            mismatches++;
          end
          if (m_data_i[OutDataWidth-1:OvfBit+1] !== '0) begin
            $display("%0t: pad bits expected 0 actual %h",
                     $time, m_data_i[OutDataWidth-1:OvfBit+1]);
            mismatches++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        products_due.push_back(hamilton_product(s_data_i));
      end
      due_count = products_due.size();
    end
  end

endmodule

>>> tb/sv/tb_quaternion_multiply_unit.sv
// Testbench top for the quaternion multiply unit: clock, reset, stimulus and verdict.
module tb_quaternion_multiply_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              CompWidth    = qmul_pkg::CompWidth;
  localparam int              NumComp      = qmul_pkg::NumComp;
  localparam int              InDataWidth  = qmul_pkg::InDataWidth;
  localparam int              OutDataWidth = qmul_pkg::OutDataWidth;
  localparam int              NumRandom    = 450;
  localparam int              IdleLimit    = 2000;
  localparam int              DrainCycles  = 8;
  localparam qmul_pkg::comp_t QMax         = 16'sh7fff;
  localparam qmul_pkg::comp_t QMin         = 16'sh8000;
  localparam qmul_pkg::comp_t QOne         = 16'sh4000;
  localparam qmul_pkg::comp_t QNegOne      = 16'shc000;
  localparam qmul_pkg::comp_t QZero        = 16'sh0000;

  logic                    clk     = 1'b0;
  logic                    rst_n   = 1'b0;
  logic                    s_valid = 1'b0;
  logic                    s_ready;
  logic [InDataWidth-1:0]  s_data  = '0;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [OutDataWidth-1:0] m_data;
  int                      fail_count;
  int                      pending;
  int                      burst_left = 0;

  quaternion_multiply_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  qmul_product_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [InDataWidth-1:0] pack_operands(
    input qmul_pkg::comp_t aw, input qmul_pkg::comp_t ax,
    input qmul_pkg::comp_t ay, input qmul_pkg::comp_t az,
    input qmul_pkg::comp_t bw, input qmul_pkg::comp_t bx,
    input qmul_pkg::comp_t by, input qmul_pkg::comp_t bz
  );
    logic [InDataWidth-1:0] d;
    d = '0;
    d[0*CompWidth +: CompWidth] = aw;
    d[1*CompWidth +: CompWidth] = ax;
    d[2*CompWidth +: CompWidth] = ay;
    d[3*CompWidth +: CompWidth] = az;
    d[4*CompWidth +: CompWidth] = bw;
    d[5*CompWidth +: CompWidth] = bx;
    d[6*CompWidth +: CompWidth] = by;
    d[7*CompWidth +: CompWidth] = bz;
    return d;
  endfunction

  function automatic qmul_pkg::comp_t pick_comp();
    case ($urandom_range(0, 7))
      0:       return QMax;
      1:       return QMin;
      2:       return QZero;
      3:       return QOne;
      4:       return QNegOne;
      5:       return qmul_pkg::comp_t'($urandom_range(0, 63)) - qmul_pkg::comp_t'(32);
      default: return qmul_pkg::comp_t'($urandom);
    endcase
  endfunction

  function automatic logic [InDataWidth-1:0] random_operands();
    logic [InDataWidth-1:0] d;
    if ($urandom_range(0, 1) == 0) begin
      for (int i = 0; i < InDataWidth / 32; i++) d[i*32 +: 32] = $urandom;
    end else begin
      for (int i = 0; i < 2 * NumComp; i++) d[i*CompWidth +: CompWidth] = pick_comp();
    end
    return d;
  endfunction

  // sender: bursts of random length with random gaps
  task automatic send_request(input logic [InDataWidth-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_valid <= 1'b1;
    s_data  <= data;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
    burst_left--;
  endtask

  // receiver: stall mode is redrawn at random intervals
  int stall_mode = 0;
  int stall_cnt  = 0;
  int phase_cnt  = 0;
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt  = $urandom_range(20, 80);
    end else begin
      stall_cnt--;
    end
    phase_cnt++;
    case (stall_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= ($urandom_range(0, 1) == 0);
      2:       m_ready <= ($urandom_range(0, 9) == 0);
      default: m_ready <= ((phase_cnt % 7) < 4);
    endcase
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(pack_operands(QZero, QZero, QZero, QZero, QZero, QZero, QZero, QZero));
    send_request(pack_operands(QOne, QZero, QZero, QZero, QOne, QZero, QZero, QZero));
    // i*j, j*k, k*i, i*i
    send_request(pack_operands(QZero, QOne, QZero, QZero, QZero, QZero, QOne, QZero));
    send_request(pack_operands(QZero, QZero, QOne, QZero, QZero, QZero, QZero, QOne));
    send_request(pack_operands(QZero, QZero, QZero, QOne, QZero, QOne, QZero, QZero));
    send_request(pack_operands(QZero, QOne, QZero, QZero, QZero, QOne, QZero, QZero));
    // saturation with all extremes
    send_request(pack_operands(QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin));
    send_request(pack_operands(QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax));
    send_request(pack_operands(QMax, QMax, QMax, QMax, QMin, QMin, QMin, QMin));
    send_request(pack_operands(QMin, QMax, QMin, QMax, QMax, QMin, QMax, QMin));
    send_request(pack_operands(QZero, QMin, QMin, QMin, QZero, QMin, QMin, QMin));
    // rounding ties and near-boundary values
    send_request(pack_operands(16'sd1, QZero, QZero, QZero, 16'sd8192, QZero, QZero, QZero));
    send_request(pack_operands(-16'sd1, QZero, QZero, QZero, 16'sd8192, QZero, QZero, QZero));
    send_request(pack_operands(-16'sd1, QZero, QZero, QZero, 16'sd8193, QZero, QZero, QZero));
    send_request(pack_operands(16'sd3, QZero, QZero, QZero, 16'sd8191, QZero, QZero, QZero));
    send_request(pack_operands(QMin, QZero, QZero, QZero, QOne, QZero, QZero, QZero));
    send_request(pack_operands(QMin, QZero, QZero, QZero, QNegOne, QZero, QZero, QZero));
    send_request(pack_operands(QMax, QZero, QZero, QZero, QOne, QZero, QZero, QZero));
    send_request(pack_operands(QMin, QMin, QZero, QZero, QMin, QMin, QZero, QZero));

    for (int n = 0; n < NumRandom; n++) send_request(random_operands());
    s_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
